// ===== rtl/core/hvsp_pkg.sv =====
// ----------------------------------------------------------------------------
// hvsp_pkg
// Types, protocol constants and frame sequence tables for the high-voltage
// serial programming master.
// ----------------------------------------------------------------------------
package hvsp_pkg;

  // operation codes
  typedef enum logic [2:0] {
    OP_READ_SIG    = 3'd0,
    OP_READ_LFUSE  = 3'd1,
    OP_READ_HFUSE  = 3'd2,
    OP_READ_EFUSE  = 3'd3,
    OP_WRITE_LFUSE = 3'd4,
    OP_WRITE_HFUSE = 3'd5,
    OP_WRITE_EFUSE = 3'd6
  } op_t;

  localparam logic [3:0] NUM_OPS = 4'd7;

  // kind of one sequence step
  typedef enum logic [1:0] {
    KIND_FRAME         = 2'd0,
    KIND_FRAME_OPERAND = 2'd1,
    KIND_POLL          = 2'd2
  } kind_t;

  // slot positions inside an 11-slot frame
  localparam logic [3:0] DATA_LAST_SLOT  = 4'd8;
  localparam logic [3:0] FRAME_LAST_SLOT = 4'd10;

  // sequence lengths in steps
  localparam logic [2:0] LEN_READ_SIG  = 3'd4;
  localparam logic [2:0] LEN_READ_FUSE = 3'd3;
  localparam logic [2:0] LEN_WRITE     = 3'd7;

  // data bytes
  localparam logic [7:0] DATA_NONE      = 8'h00;
  localparam logic [7:0] DATA_READ_SIG  = 8'h08;
  localparam logic [7:0] DATA_READ_FUSE = 8'h04;
  localparam logic [7:0] DATA_WRITE     = 8'h40;

  // instruction bytes
  localparam logic [7:0] INS_LOAD_CMD   = 8'h4C;
  localparam logic [7:0] INS_LOAD_ADDR  = 8'h0C;
  localparam logic [7:0] INS_LOAD_DATA  = 8'h2C;
  localparam logic [7:0] INS_SIG_1      = 8'h68;
  localparam logic [7:0] INS_SIG_2      = 8'h6C;
  localparam logic [7:0] INS_HFUSE_RD_1 = 8'h7A;
  localparam logic [7:0] INS_HFUSE_RD_2 = 8'h7E;
  localparam logic [7:0] INS_EFUSE_RD_1 = 8'h6A;
  localparam logic [7:0] INS_EFUSE_RD_2 = 8'h6E;
  localparam logic [7:0] INS_LFUSE_WR_1 = 8'h64;
  localparam logic [7:0] INS_LFUSE_WR_2 = 8'h6C;
  localparam logic [7:0] INS_HFUSE_WR_1 = 8'h74;
  localparam logic [7:0] INS_HFUSE_WR_2 = 8'h7C;
  localparam logic [7:0] INS_EFUSE_WR_1 = 8'h66;
  localparam logic [7:0] INS_EFUSE_WR_2 = 8'h6E;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] data;
    logic [7:0] instr;
  } seq_entry_t;

  // one accepted slot word
  typedef struct packed {
    logic       start_req;
    logic [2:0] operation;
    logic [7:0] operand;
    logic       sdo;
  } item_t;

  // one result word
  typedef struct packed {
    logic       sdi;
    logic       sii;
    logic       clock_pulse;
    logic       busy_res;
    logic       waiting_ready;
    logic       done_res;
    logic [7:0] read_data;
  } result_t;

  function automatic seq_entry_t mk(input kind_t k, input logic [7:0] d,
                                    input logic [7:0] i);
    seq_entry_t e;
    e.kind  = k;
    e.data  = d;
    e.instr = i;
    return e;
  endfunction

  // frame sequence per operation and step
  function automatic seq_entry_t seq_lookup(input logic [2:0] op, input logic [2:0] step);
    seq_entry_t e;
    logic [7:0] ins_a;
    logic [7:0] ins_b;
    e     = mk(KIND_POLL, DATA_NONE, DATA_NONE);
    ins_a = INS_SIG_1;
    ins_b = INS_SIG_2;
    unique case (op)
      OP_READ_SIG: begin
        unique case (step)
          3'd0:    e = mk(KIND_FRAME, DATA_READ_SIG, INS_LOAD_CMD);
          3'd1:    e = mk(KIND_FRAME_OPERAND, DATA_NONE, INS_LOAD_ADDR);
          3'd2:    e = mk(KIND_FRAME, DATA_NONE, INS_SIG_1);
          3'd3:    e = mk(KIND_FRAME, DATA_NONE, INS_SIG_2);
          default: e = mk(KIND_POLL, DATA_NONE, DATA_NONE);
        endcase
      end
      OP_READ_LFUSE, OP_READ_HFUSE, OP_READ_EFUSE: begin
        if (op == OP_READ_HFUSE) begin
          ins_a = INS_HFUSE_RD_1;
          ins_b = INS_HFUSE_RD_2;
        end else if (op == OP_READ_EFUSE) begin
          ins_a = INS_EFUSE_RD_1;
          ins_b = INS_EFUSE_RD_2;
        end
        unique case (step)
          3'd0:    e = mk(KIND_FRAME, DATA_READ_FUSE, INS_LOAD_CMD);
          3'd1:    e = mk(KIND_FRAME, DATA_NONE, ins_a);
          3'd2:    e = mk(KIND_FRAME, DATA_NONE, ins_b);
          default: e = mk(KIND_POLL, DATA_NONE, DATA_NONE);
        endcase
      end
      OP_WRITE_LFUSE, OP_WRITE_HFUSE, OP_WRITE_EFUSE: begin
        if (op == OP_WRITE_LFUSE) begin
          ins_a = INS_LFUSE_WR_1;
          ins_b = INS_LFUSE_WR_2;
        end else if (op == OP_WRITE_HFUSE) begin
          ins_a = INS_HFUSE_WR_1;
          ins_b = INS_HFUSE_WR_2;
        end else begin
          ins_a = INS_EFUSE_WR_1;
          ins_b = INS_EFUSE_WR_2;
        end
        unique case (step)
          3'd0:    e = mk(KIND_FRAME, DATA_WRITE, INS_LOAD_CMD);
          3'd1:    e = mk(KIND_FRAME_OPERAND, DATA_NONE, INS_LOAD_DATA);
          3'd2:    e = mk(KIND_FRAME, DATA_NONE, ins_a);
          3'd3:    e = mk(KIND_FRAME, DATA_NONE, ins_b);
          3'd5:    e = mk(KIND_FRAME, DATA_NONE, INS_LOAD_CMD);
          default: e = mk(KIND_POLL, DATA_NONE, DATA_NONE);
        endcase
      end
      default: e = mk(KIND_POLL, DATA_NONE, DATA_NONE);
    endcase
    return e;
  endfunction

  // number of steps per operation
  function automatic logic [2:0] seq_length(input logic [2:0] op);
    logic [2:0] len;
    unique case (op)
      OP_READ_SIG:                                   len = LEN_READ_SIG;
      OP_READ_LFUSE, OP_READ_HFUSE, OP_READ_EFUSE:   len = LEN_READ_FUSE;
      default:                                       len = LEN_WRITE;
    endcase
    return len;
  endfunction

endpackage

// ===== rtl/core/hvsp_in_reg.sv =====
// ----------------------------------------------------------------------------
// hvsp_in_reg
// Input register: captures one slot word and holds it until the sequencer
// takes it.
// ----------------------------------------------------------------------------
module hvsp_in_reg
  import hvsp_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_stall,
  input  item_t in_item,
  input  logic  down_ready,
  output logic  fire,
  output item_t item
);

  logic valid;

  // word moves on when the result side has room
  assign fire     = valid && down_ready;
  assign in_stall = valid && !down_ready;

  // valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (!in_stall) begin
      valid <= in_valid;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      item <= in_item;
    end
  end

endmodule

// ===== rtl/core/hvsp_slot_engine.sv =====
// ----------------------------------------------------------------------------
// hvsp_slot_engine
// Sequencer state and the per-slot logic: frame shifting, sdo capture,
// ready polling and end-of-sequence detection.
// ----------------------------------------------------------------------------
module hvsp_slot_engine
  import hvsp_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    fire,
  input  item_t   item,
  output result_t result
);

  logic       running;
  logic [2:0] step_index;
  logic [3:0] slot_count;
  logic [7:0] data_shift;
  logic [7:0] instr_shift;
  logic [7:0] read_shift;
  logic [2:0] active_operation;
  logic [7:0] held_operand;

  logic       running_next;
  logic [2:0] step_index_next;
  logic [3:0] slot_count_next;
  logic [7:0] data_shift_next;
  logic [7:0] instr_shift_next;
  logic [7:0] read_shift_next;
  logic [2:0] active_operation_next;
  logic [7:0] held_operand_next;

  seq_entry_t entry;
  logic       active;
  logic       advance;
  logic [2:0] step_inc;

  // slot evaluation
  always_comb begin
    running_next          = running;
    step_index_next       = step_index;
    slot_count_next       = slot_count;
    data_shift_next       = data_shift;
    instr_shift_next      = instr_shift;
    read_shift_next       = read_shift;
    active_operation_next = active_operation;
    held_operand_next     = held_operand;
    result                = '0;
    advance               = 1'b0;
    active                = running;
    step_inc              = '0;

    // start from idle
    if (!running) begin
      if (item.start_req && ({1'b0, item.operation} < NUM_OPS)) begin
        active                = 1'b1;
        running_next          = 1'b1;
        active_operation_next = item.operation;
        held_operand_next     = item.operand;
        step_index_next       = '0;
        slot_count_next       = '0;
      end
    end

    entry = seq_lookup(active_operation_next, step_index_next);

    if (active) begin
      result.busy_res = 1'b1;
      if (entry.kind == KIND_POLL) begin
        result.waiting_ready = 1'b1;
        advance              = item.sdo;
      end else begin
        result.clock_pulse = 1'b1;
        if (slot_count_next == '0) begin
          data_shift_next  = (entry.kind == KIND_FRAME_OPERAND) ? held_operand_next
                                                                 : entry.data;
          instr_shift_next = entry.instr;
          read_shift_next  = '0;
        end else if (slot_count_next <= DATA_LAST_SLOT) begin
          read_shift_next  = {read_shift[6:0], item.sdo};
          result.sdi       = data_shift[7];
          result.sii       = instr_shift[7];
          data_shift_next  = {data_shift[6:0], 1'b0};
          instr_shift_next = {instr_shift[6:0], 1'b0};
        end
        if (slot_count_next >= FRAME_LAST_SLOT) begin
          slot_count_next = '0;
          advance         = 1'b1;
        end else begin
          slot_count_next = slot_count_next + 4'd1;
        end
      end

      // step advance and end of sequence
      if (advance) begin
        step_inc        = step_index_next + 3'd1;
        step_index_next = step_inc;
        if (step_inc >= seq_length(active_operation_next)) begin
          result.done_res = 1'b1;
          running_next    = 1'b0;
          step_index_next = '0;
          slot_count_next = '0;
          if (active_operation_next <= OP_READ_EFUSE) begin
            result.read_data = read_shift_next;
          end
        end
      end
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      running          <= 1'b0;
      step_index       <= '0;
      slot_count       <= '0;
      active_operation <= '0;
    end else if (fire) begin
      running          <= running_next;
      step_index       <= step_index_next;
      slot_count       <= slot_count_next;
      active_operation <= active_operation_next;
    end
  end

  // shift registers and held operand
  always_ff @(posedge clk) begin
    if (rst) begin
      data_shift   <= '0;
      instr_shift  <= '0;
      read_shift   <= '0;
      held_operand <= '0;
    end else if (fire) begin
      data_shift   <= data_shift_next;
      instr_shift  <= instr_shift_next;
      read_shift   <= read_shift_next;
      held_operand <= held_operand_next;
    end
  end

endmodule

// ===== rtl/core/hvsp_out_reg.sv =====
// ----------------------------------------------------------------------------
// hvsp_out_reg
// Result register: holds one result word until the receiver takes it.
// ----------------------------------------------------------------------------
module hvsp_out_reg
  import hvsp_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    load,
  input  result_t result_in,
  output logic    up_ready,
  output logic    out_valid,
  input  logic    out_stall,
  output result_t result_out
);

  // room when empty or being drained this cycle
  assign up_ready = !out_valid || !out_stall;

  // valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (up_ready) begin
      out_valid <= load;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (load && up_ready) begin
      result_out <= result_in;
    end
  end

endmodule

// ===== rtl/core/hv_serial_programming_master_unit.sv =====
// ----------------------------------------------------------------------------
// hv_serial_programming_master_unit
// High-voltage serial programming master, one slot word in, one result out.
// Path: input register, combinational slot engine, result register.
// Throughput: one slot per cycle unless a full result register is stalled.
// Reset: synchronous, active high; returns to idle with both registers empty.
// ----------------------------------------------------------------------------
module hv_serial_programming_master_unit
  import hvsp_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       start_req,
  input  logic [2:0] operation,
  input  logic [7:0] operand,
  input  logic       sdo,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       sdi,
  output logic       sii,
  output logic       clock_pulse,
  output logic       busy_res,
  output logic       waiting_ready,
  output logic       done_res,
  output logic [7:0] read_data
);

  item_t   in_item;
  item_t   item;
  result_t result;
  result_t result_out;
  logic    fire;
  logic    up_ready;

  assign in_item.start_req = start_req;
  assign in_item.operation = operation;
  assign in_item.operand   = operand;
  assign in_item.sdo       = sdo;

  hvsp_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_item    (in_item),
    .down_ready (up_ready),
    .fire       (fire),
    .item       (item)
  );

  hvsp_slot_engine u_engine (
    .clk    (clk),
    .rst    (rst),
    .fire   (fire),
    .item   (item),
    .result (result)
  );

  hvsp_out_reg u_out_reg (
    .clk        (clk),
    .rst        (rst),
    .load       (fire),
    .result_in  (result),
    .up_ready   (up_ready),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .result_out (result_out)
  );

  assign sdi           = result_out.sdi;
  assign sii           = result_out.sii;
  assign clock_pulse   = result_out.clock_pulse;
  assign busy_res      = result_out.busy_res;
  assign waiting_ready = result_out.waiting_ready;
  assign done_res      = result_out.done_res;
  assign read_data     = result_out.read_data;

  // input side only backs up behind a full, stalled result register
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled without a stalled result");

  // polling slots never clock and drive zero levels
  a_poll_quiet: assert property (@(posedge clk) disable iff (rst)
    (out_valid && waiting_ready) |-> (!clock_pulse && !sdi && !sii && busy_res))
    else $error("poll slot drives clock or data");

  // read data only shows on the done slot
  a_read_on_done: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (read_data != 8'h00)) |-> (done_res && busy_res))
    else $error("read data outside done slot");

  // an idle result carries no activity
  a_idle_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !busy_res) |-> (!clock_pulse && !waiting_ready && !done_res))
    else $error("activity on idle slot");

endmodule
